>>> rtl/kmd_pkg.sv
package kmd_pkg;

  // Fixed field widths of the row sample and of the result beat
  localparam int ROW_W  = 3;
  localparam int COL_W  = 8;
  localparam int TICK_W = 32;
  localparam int KEY_W  = 6;
  localparam int DEB_W  = 16;

  // Debounce time after reset
  localparam logic [DEB_W-1:0] DEB_RESET = 16'd5;

  // Outcome of evaluating one row sample
  typedef struct packed {
    logic             in_range;
    logic [COL_W-1:0] flips;
    logic [COL_W-1:0] rels;
    logic [KEY_W-1:0] base_key;
    logic [COL_W-1:0] row_debounced;
    logic [COL_W-1:0] active_columns;
  } kmd_row_res_t;

endpackage

>>> rtl/key_matrix_debounce_events.sv
// Channel | Ports                                          | Beat
// in      | in_valid, in_ready, in_row_index, in_column_bits, in_now_tick | one row sample
// out     | out_valid, out_ready, out_event_valid, out_key_number,       | one key event
//         | out_released, out_row_debounced, out_active_columns,         | or empty beat
//         | out_last_of_row                                              |
// cfg     | cfg_we, cfg_data                               | debounce time write
//
// A row sample yields max(1, accepted flips) result beats, one result beat per
// cycle while out_ready is high, as set by the event buffer that hands out one
// key per cycle. The event buffer registers the beats; it loads from the input
// register. Synchronous reset clears the debounced rows, the key times and the
// accumulator at once; debounce time returns to 5.
// A stalled output holds the current beat; the input register can take one
// sample while the previous row's last beat waits, then stalls.
module key_matrix_debounce_events
  import kmd_pkg::*;
#(
  parameter int ROWS    = 8,
  parameter int COLUMNS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [DEB_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ROW_W-1:0]  in_row_index,
  input  logic [COL_W-1:0]  in_column_bits,
  input  logic [TICK_W-1:0] in_now_tick,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_event_valid,
  output logic [KEY_W-1:0]  out_key_number,
  output logic              out_released,
  output logic [COL_W-1:0]  out_row_debounced,
  output logic [COL_W-1:0]  out_active_columns,
  output logic              out_last_of_row
);

  // Only rows and columns that the sample fields can reach get storage
  localparam int NR = (ROWS < (1 << ROW_W)) ? ROWS : (1 << ROW_W);
  localparam int NC = (COLUMNS < COL_W) ? COLUMNS : COL_W;
  localparam int RW = (NR > 1) ? $clog2(NR) : 1;

  logic [DEB_W-1:0]          deb_time_r;
  logic                      in_valid_r;
  logic [ROW_W-1:0]          row_r;
  logic [COL_W-1:0]          cols_r;
  logic [TICK_W-1:0]         now_r;
  logic [COL_W-1:0]          deb_rows_r [NR];
  logic [NC-1:0][TICK_W-1:0] press_r    [NR];
  logic [NC-1:0][TICK_W-1:0] release_r  [NR];
  logic [COL_W-1:0]          acc_r;

  logic [RW-1:0]             idx;
  logic                      idx_ok;
  logic [COL_W-1:0]          old_row;
  logic [NC-1:0][TICK_W-1:0] press_sel;
  logic [NC-1:0][TICK_W-1:0] release_sel;
  kmd_row_res_t              res;
  logic                      can_load;
  logic                      commit;

  // Debounce time register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_time_r <= DEB_RESET;
    end else if (cfg_we) begin
      deb_time_r <= cfg_data;
    end
  end

  // Input register: free, or emptying into the event buffer this cycle
  assign commit   = in_valid_r && can_load;
  assign in_ready = !in_valid_r || commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      row_r  <= in_row_index;
      cols_r <= in_column_bits;
      now_r  <= in_now_tick;
    end
  end

  // Select the stored state of the sampled row
  assign idx    = row_r[RW-1:0];
  assign idx_ok = ({{(32-ROW_W){1'b0}}, row_r} < 32'(NR));

  always_comb begin
    old_row     = '0;
    press_sel   = '0;
    release_sel = '0;
    if (idx_ok) begin
      old_row     = deb_rows_r[idx];
      press_sel   = press_r[idx];
      release_sel = release_r[idx];
    end
  end

  kmd_row_eval #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS),
    .NC      (NC)
  ) u_eval (
    .row_index     (row_r),
    .column_bits   (cols_r),
    .now_tick      (now_r),
    .debounce_time (deb_time_r),
    .old_row       (old_row),
    .press_time    (press_sel),
    .release_time  (release_sel),
    .active_acc    (acc_r),
    .res           (res)
  );

  // Update row state as the sample moves into the event buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NR; r++) begin
        deb_rows_r[r] <= '0;
        press_r[r]    <= '0;
        release_r[r]  <= '0;
      end
      acc_r <= '0;
    end else if (commit) begin
      acc_r <= res.active_columns;
      if (res.in_range && idx_ok) begin
        deb_rows_r[idx] <= res.row_debounced;
        for (int c = 0; c < NC; c++) begin
          if (res.flips[c] && !res.rels[c]) press_r[idx][c] <= now_r;
          if (res.flips[c] && res.rels[c])  release_r[idx][c] <= now_r;
        end
      end
    end
  end

  kmd_event_out u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (commit),
    .res                (res),
    .can_load           (can_load),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_valid    (out_event_valid),
    .out_key_number     (out_key_number),
    .out_released       (out_released),
    .out_row_debounced  (out_row_debounced),
    .out_active_columns (out_active_columns),
    .out_last_of_row    (out_last_of_row)
  );

endmodule

>>> rtl/kmd_row_eval.sv
module kmd_row_eval
  import kmd_pkg::*;
#(
  parameter int ROWS    = 8,
  parameter int COLUMNS = 8,
  parameter int NC      = 8
) (
  input  logic [ROW_W-1:0]           row_index,
  input  logic [COL_W-1:0]           column_bits,
  input  logic [TICK_W-1:0]          now_tick,
  input  logic [DEB_W-1:0]           debounce_time,
  input  logic [COL_W-1:0]           old_row,
  input  logic [NC-1:0][TICK_W-1:0]  press_time,
  input  logic [NC-1:0][TICK_W-1:0]  release_time,
  input  logic [COL_W-1:0]           active_acc,
  output kmd_row_res_t               res
);

  localparam logic [COL_W-1:0] COL_KEEP =
    (COLUMNS >= COL_W) ? {COL_W{1'b1}} : COL_W'((1 << COLUMNS) - 1);

  logic [COL_W-1:0]          cols;
  logic [COL_W-1:0]          diff;
  logic [COL_W-1:0]          flips;
  logic [COL_W-1:0]          rels;
  logic [COL_W-1:0]          new_row;
  logic [COL_W-1:0]          acc_base;
  logic [NC-1:0][TICK_W-1:0] since_press;
  logic [NC-1:0][TICK_W-1:0] since_rel;
  logic [TICK_W-1:0]         limit;
  logic [ROW_W+5:0]          base_full;
  logic                      in_range;

  assign in_range  = ({{(32-ROW_W){1'b0}}, row_index} < 32'(ROWS));
  assign cols      = column_bits & COL_KEEP;
  assign diff      = cols ^ old_row;
  assign limit     = {{(TICK_W-DEB_W){1'b0}}, debounce_time};
  assign base_full = (ROW_W+6)'(row_index) * (ROW_W+6)'(COLUMNS);
  assign acc_base  = (row_index == '0) ? '0 : active_acc;

  // Check each differing column against the time of its opposite transition
  always_comb begin
    flips = '0;
    rels  = '0;
    for (int c = 0; c < NC; c++) begin
      since_press[c] = now_tick - press_time[c];
      since_rel[c]   = now_tick - release_time[c];
      if (diff[c]) begin
        if (cols[c]) begin
          flips[c] = (since_rel[c] > limit);
        end else begin
          flips[c] = (since_press[c] > limit);
          rels[c]  = (since_press[c] > limit);
        end
      end
    end
  end

  assign new_row = old_row ^ flips;

  // Out-of-range rows change nothing and report an empty beat
  always_comb begin
    res.in_range = in_range;
    res.base_key = base_full[KEY_W-1:0];
    if (in_range) begin
      res.flips          = flips;
      res.rels           = rels;
      res.row_debounced  = new_row;
      res.active_columns = acc_base | cols | new_row;
    end else begin
      res.flips          = '0;
      res.rels           = '0;
      res.row_debounced  = '0;
      res.active_columns = active_acc;
    end
  end

endmodule

>>> rtl/kmd_event_out.sv
module kmd_event_out
  import kmd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  kmd_row_res_t     res,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_event_valid,
  output logic [KEY_W-1:0] out_key_number,
  output logic             out_released,
  output logic [COL_W-1:0] out_row_debounced,
  output logic [COL_W-1:0] out_active_columns,
  output logic             out_last_of_row
);

  logic             valid_r;
  logic [COL_W-1:0] pend_r;
  logic [COL_W-1:0] rels_r;
  logic [KEY_W-1:0] base_r;
  logic [COL_W-1:0] row_r;
  logic [COL_W-1:0] act_r;
  logic [COL_W-1:0] low_bit;
  logic [2:0]       low_idx;
  logic             last;

  // Pick the lowest pending column
  assign low_bit = pend_r & (~pend_r + COL_W'(1));
  always_comb begin
    low_idx = '0;
    for (int c = COL_W - 1; c >= 0; c--) begin
      if (pend_r[c]) low_idx = 3'(c);
    end
  end

  assign last     = ((pend_r & ~low_bit) == '0);
  assign can_load = !valid_r || (out_ready && last);

  // Hold the row's events and step through them one beat at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready && valid_r && last) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pend_r <= res.flips;
      rels_r <= res.rels;
      base_r <= res.base_key;
      row_r  <= res.row_debounced;
      act_r  <= res.active_columns;
    end else if (out_ready && valid_r) begin
      pend_r <= pend_r & ~low_bit;
    end
  end

  assign out_valid          = valid_r;
  assign out_event_valid    = (pend_r != '0);
  assign out_key_number     = out_event_valid ? base_r + KEY_W'(low_idx) : '0;
  assign out_released       = out_event_valid && rels_r[low_idx];
  assign out_row_debounced  = row_r;
  assign out_active_columns = act_r;
  assign out_last_of_row    = last;

endmodule
